// ===== rtl/utf8_enc_pkg.sv =====
package utf8_enc_pkg;

  localparam int CP_W   = 31;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 3;
  localparam int CNT_W  = 16;

  localparam logic [CNT_W-1:0] CAPACITY_RESET = 16'd1024;

  // length thresholds
  localparam logic [CP_W-1:0] LIM_1B = 31'd128;
  localparam logic [CP_W-1:0] LIM_2B = 31'd2048;
  localparam logic [CP_W-1:0] LIM_3B = 31'd65536;
  localparam logic [CP_W-1:0] LIM_4B = 31'd2097152;
  localparam logic [CP_W-1:0] LIM_5B = 31'd67108864;

  // lead byte prefixes and continuation mark
  localparam logic [BYTE_W-1:0] LEAD_2B = 8'd192;
  localparam logic [BYTE_W-1:0] LEAD_3B = 8'd224;
  localparam logic [BYTE_W-1:0] LEAD_4B = 8'd240;
  localparam logic [BYTE_W-1:0] LEAD_5B = 8'd248;
  localparam logic [BYTE_W-1:0] LEAD_6B = 8'd252;
  localparam logic [BYTE_W-1:0] CONT_MK = 8'd128;

  typedef struct packed {
    logic [LEN_W-1:0] len;  // character length in bytes, 1..6
    logic [LEN_W-1:0] idx;  // byte position within character
  } enc_sel_t;

endpackage

// ===== rtl/utf8_encoder.sv =====
// UTF-8 encoder, original 31-bit form, one to six bytes per character.
// Input channel (in_valid/in_ready/code_point) takes one code point per
// transfer; the output channel (out_valid/out_ready) gives one byte per
// transfer with last_of_char, end_of_string and overflow flags.
// cfg_we/cfg_wdata set the output buffer capacity (reset 1024); write it
// only while the block is idle.
// The first byte of a character passes through the holding register and
// then the output register before it is offered. A character of L bytes
// (1 to 6) passes through the output register one byte per cycle while the
// receiver is ready; the next code point is taken in the cycle its
// predecessor's last byte is registered, so the output runs without
// gaps. A zero code point emits one 0 byte and clears the byte
// count; a capacity miss emits one overflow result and also clears the count.
// When the receiver stalls, the output register holds its byte; the input
// side takes at most one more code point into the holding register and then
// stops until the held character has drained.
// Reset clears the held item, the output valid flag and the byte count, and
// restores the capacity to 1024.
module utf8_encoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [utf8_enc_pkg::CP_W-1:0]       code_point,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [utf8_enc_pkg::BYTE_W-1:0]     out_byte,
  output logic                                last_of_char,
  output logic                                end_of_string,
  output logic                                overflow,
  input  logic                                cfg_we,
  input  logic [utf8_enc_pkg::CNT_W-1:0]      cfg_wdata
);
  import utf8_enc_pkg::*;

  logic              hold_valid;
  logic [CP_W-1:0]   cp_q;
  logic [LEN_W-1:0]  len_q;
  logic [LEN_W-1:0]  idx_q;
  logic [CNT_W-1:0]  bytes_used;
  logic [CNT_W-1:0]  capacity_bytes;

  logic [LEN_W-1:0]  in_len;
  logic              emit;
  logic              fits;
  logic              is_ovf;
  logic              is_eos;
  logic              is_last;
  logic              done;
  logic [BYTE_W-1:0] enc_byte;
  enc_sel_t          sel;

  always_comb begin
    if (code_point < LIM_1B)      in_len = 3'd1;
    else if (code_point < LIM_2B) in_len = 3'd2;
    else if (code_point < LIM_3B) in_len = 3'd3;
    else if (code_point < LIM_4B) in_len = 3'd4;
    else if (code_point < LIM_5B) in_len = 3'd5;
    else                          in_len = 3'd6;
  end

  assign fits = ({1'b0, bytes_used} + (CNT_W+1)'(len_q)) < {1'b0, capacity_bytes};
  // overflow and terminator only decided on the first byte
  assign is_ovf  = (idx_q == '0) && !fits;
  assign is_eos  = (idx_q == '0) && fits && (cp_q == '0);
  assign is_last = is_ovf || is_eos || (idx_q == len_q - LEN_W'(1));

  assign emit     = hold_valid && (!out_valid || out_ready);
  assign done     = emit && is_last;
  assign in_ready = !hold_valid || done;

  assign sel.len = len_q;
  assign sel.idx = idx_q;

  utf8_enc_byte u_byte (
    .cp       (cp_q),
    .sel      (sel),
    .enc_byte (enc_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid     <= 1'b0;
      idx_q          <= '0;
      bytes_used     <= '0;
      capacity_bytes <= CAPACITY_RESET;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_bytes <= cfg_wdata;
      end

      if (in_valid && in_ready) begin
        hold_valid <= 1'b1;
        idx_q      <= '0;
      end else if (done) begin
        hold_valid <= 1'b0;
      end else if (emit) begin
        idx_q <= idx_q + LEN_W'(1);
      end

      if (emit && idx_q == '0) begin
        if (is_ovf || is_eos) bytes_used <= '0;
        else                  bytes_used <= CNT_W'({1'b0, bytes_used} + (CNT_W+1)'(len_q));
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cp_q  <= code_point;
      len_q <= in_len;
    end
    if (emit) begin
      out_byte      <= (is_ovf || is_eos) ? '0 : enc_byte;
      last_of_char  <= is_last;
      end_of_string <= is_eos;
      overflow      <= is_ovf;
    end
  end

endmodule

// ===== rtl/utf8_enc_byte.sv =====
module utf8_enc_byte (
  input  logic [utf8_enc_pkg::CP_W-1:0]   cp,
  input  utf8_enc_pkg::enc_sel_t          sel,
  output logic [utf8_enc_pkg::BYTE_W-1:0] enc_byte
);
  import utf8_enc_pkg::*;

  logic [LEN_W-1:0] k;  // continuation slices still to follow

  assign k = sel.len - sel.idx - LEN_W'(1);

  always_comb begin
    enc_byte = '0;
    if (sel.idx == '0) begin
      case (sel.len)
        3'd1:    enc_byte = {1'b0, cp[6:0]};
        3'd2:    enc_byte = LEAD_2B | {3'b0, cp[10:6]};
        3'd3:    enc_byte = LEAD_3B | {4'b0, cp[15:12]};
        3'd4:    enc_byte = LEAD_4B | {5'b0, cp[20:18]};
        3'd5:    enc_byte = LEAD_5B | {6'b0, cp[25:24]};
        3'd6:    enc_byte = LEAD_6B | {7'b0, cp[30]};
        default: enc_byte = '0;
      endcase
    end else begin
      case (k)
        3'd0:    enc_byte = CONT_MK | {2'b0, cp[5:0]};
        3'd1:    enc_byte = CONT_MK | {2'b0, cp[11:6]};
        3'd2:    enc_byte = CONT_MK | {2'b0, cp[17:12]};
        3'd3:    enc_byte = CONT_MK | {2'b0, cp[23:18]};
        3'd4:    enc_byte = CONT_MK | {2'b0, cp[29:24]};
        default: enc_byte = '0;
      endcase
    end
  end

endmodule

// ===== rtl/utf8_enc_chk.sv =====
module utf8_enc_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [utf8_enc_pkg::BYTE_W-1:0] out_byte,
  input logic                            last_of_char,
  input logic                            end_of_string,
  input logic                            overflow
);
  import utf8_enc_pkg::*;

  // a stalled output transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_char)
      && $stable(end_of_string) && $stable(overflow))
    else $error("output changed while stalled");

  a_ovf_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> out_byte == '0 && last_of_char && !end_of_string)
    else $error("malformed overflow result");

  a_eos_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_string |-> out_byte == '0 && last_of_char && !overflow)
    else $error("malformed terminator result");

  // a non-final byte never ends a string or flags overflow and is a lead or continuation byte
  a_cont_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_char |-> !end_of_string && !overflow && out_byte[7:6] == 2'b11
      || out_valid && !last_of_char && out_byte[7:6] == 2'b10 && !end_of_string && !overflow)
    else $error("non-final byte has wrong form");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind utf8_encoder utf8_enc_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .last_of_char  (last_of_char),
  .end_of_string (end_of_string),
  .overflow      (overflow)
);
